FILE: design/pcvl_pkg.sv
// Shared types, register map and BT.601 weights for the pixel channel view block.
package pcvl_pkg;

    localparam int unsigned COMP_W = 8;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned ADDR_W = 4;
    localparam int unsigned WEIGHT_W = 16;
    localparam int unsigned PROD_W = COMP_W + WEIGHT_W;
    localparam int unsigned SUM_W = PROD_W + 2;

    typedef enum logic [2:0] {
        CH_RED   = 3'd0,
        CH_GREEN = 3'd1,
        CH_BLUE  = 3'd2,
        CH_LUMA  = 3'd3,
        CH_CB    = 3'd4,
        CH_CR    = 3'd5,
        CH_PASS  = 3'd6
    } channel_t;

    typedef enum logic [1:0] {
        REG_CHANNEL_SELECT   = 2'd0,
        REG_LSB_VIEW_ENABLE  = 2'd1,
        REG_SOURCE_HAS_ALPHA = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [2:0] channel_select;
        logic       lsb_view_enable;
        logic       source_has_alpha;
    } cfg_t;

    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
        logic [COMP_W-1:0] alpha;
    } pixel_t;

    localparam logic [WEIGHT_W-1:0] W_Y_R  = 16'd19595;
    localparam logic [WEIGHT_W-1:0] W_Y_G  = 16'd38470;
    localparam logic [WEIGHT_W-1:0] W_Y_B  = 16'd7471;
    localparam logic [WEIGHT_W-1:0] W_CB_R = 16'd11058;
    localparam logic [WEIGHT_W-1:0] W_CB_G = 16'd21710;
    localparam logic [WEIGHT_W-1:0] W_CB_B = 16'd32768;
    localparam logic [WEIGHT_W-1:0] W_CR_R = 16'd32768;
    localparam logic [WEIGHT_W-1:0] W_CR_G = 16'd27439;
    localparam logic [WEIGHT_W-1:0] W_CR_B = 16'd5329;

    localparam logic signed [SUM_W-1:0] OFFSET_Q16 = 26'sd8388608;

    localparam logic [COMP_W-1:0] COMP_MAX = 8'hFF;

endpackage

FILE: design/pcvl_regs.sv
// APB configuration registers for the pixel channel view block.
module pcvl_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pcvl_pkg::ADDR_W-1:0]   paddr,
    input  logic [pcvl_pkg::DATA_W-1:0]   pwdata,
    output logic [pcvl_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output pcvl_pkg::cfg_t                cfg
);

    pcvl_pkg::cfg_t cfg_reg;
    pcvl_pkg::cfg_t cfg_next;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                pcvl_pkg::REG_CHANNEL_SELECT:   cfg_next.channel_select   = pwdata[2:0];
                pcvl_pkg::REG_LSB_VIEW_ENABLE:  cfg_next.lsb_view_enable  = pwdata[0];
                pcvl_pkg::REG_SOURCE_HAS_ALPHA: cfg_next.source_has_alpha = pwdata[0];
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_select   <= pcvl_pkg::CH_PASS;
            cfg_reg.lsb_view_enable  <= 1'b0;
            cfg_reg.source_has_alpha <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            pcvl_pkg::REG_CHANNEL_SELECT:   prdata[2:0] = cfg_reg.channel_select;
            pcvl_pkg::REG_LSB_VIEW_ENABLE:  prdata[0]   = cfg_reg.lsb_view_enable;
            pcvl_pkg::REG_SOURCE_HAS_ALPHA: prdata[0]   = cfg_reg.source_has_alpha;
            default:                        prdata      = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/pcvl_view.sv
// Combinational view logic: channel pick, BT.601 gray levels, LSB plane and alpha.
module pcvl_view (
    input  pcvl_pkg::cfg_t   cfg,
    input  pcvl_pkg::pixel_t pix,
    output pcvl_pkg::pixel_t view
);

    function automatic logic [pcvl_pkg::COMP_W-1:0] gray_clamp(
        input logic signed [pcvl_pkg::SUM_W-1:0] s
    );
        logic [pcvl_pkg::COMP_W-1:0] g;
        if (s[pcvl_pkg::SUM_W-1])
            g = '0;
        else if (s[pcvl_pkg::SUM_W-2])
            g = pcvl_pkg::COMP_MAX;
        else
            g = s[pcvl_pkg::SUM_W-3 -: pcvl_pkg::COMP_W];
        return g;
    endfunction

    function automatic logic signed [pcvl_pkg::SUM_W-1:0] ext(
        input logic [pcvl_pkg::PROD_W-1:0] p
    );
        return $signed({2'b00, p});
    endfunction

    logic [pcvl_pkg::PROD_W-1:0]        y_r, y_g, y_b;
    logic [pcvl_pkg::PROD_W-1:0]        cb_r, cb_g, cb_b;
    logic [pcvl_pkg::PROD_W-1:0]        cr_r, cr_g, cr_b;
    logic signed [pcvl_pkg::SUM_W-1:0]  y_sum, cb_sum, cr_sum;
    logic [pcvl_pkg::COMP_W-1:0]        y_gray, cb_gray, cr_gray;
    pcvl_pkg::pixel_t                   sel;

    assign y_r  = pix.red   * pcvl_pkg::W_Y_R;
    assign y_g  = pix.green * pcvl_pkg::W_Y_G;
    assign y_b  = pix.blue  * pcvl_pkg::W_Y_B;
    assign cb_r = pix.red   * pcvl_pkg::W_CB_R;
    assign cb_g = pix.green * pcvl_pkg::W_CB_G;
    assign cb_b = pix.blue  * pcvl_pkg::W_CB_B;
    assign cr_r = pix.red   * pcvl_pkg::W_CR_R;
    assign cr_g = pix.green * pcvl_pkg::W_CR_G;
    assign cr_b = pix.blue  * pcvl_pkg::W_CR_B;

    assign y_sum  = ext(y_r) + ext(y_g) + ext(y_b);
    assign cb_sum = pcvl_pkg::OFFSET_Q16 - ext(cb_r) - ext(cb_g) + ext(cb_b);
    assign cr_sum = pcvl_pkg::OFFSET_Q16 + ext(cr_r) - ext(cr_g) - ext(cr_b);

    assign y_gray  = gray_clamp(y_sum);
    assign cb_gray = gray_clamp(cb_sum);
    assign cr_gray = gray_clamp(cr_sum);

    always_comb
    begin
        sel.alpha = pcvl_pkg::COMP_MAX;
        unique case (cfg.channel_select)
            pcvl_pkg::CH_RED:
            begin
                sel.red   = pix.red;
                sel.green = '0;
                sel.blue  = '0;
            end
            pcvl_pkg::CH_GREEN:
            begin
                sel.red   = '0;
                sel.green = pix.green;
                sel.blue  = '0;
            end
            pcvl_pkg::CH_BLUE:
            begin
                sel.red   = '0;
                sel.green = '0;
                sel.blue  = pix.blue;
            end
            pcvl_pkg::CH_LUMA:
            begin
                sel.red   = y_gray;
                sel.green = y_gray;
                sel.blue  = y_gray;
            end
            pcvl_pkg::CH_CB:
            begin
                sel.red   = cb_gray;
                sel.green = cb_gray;
                sel.blue  = cb_gray;
            end
            pcvl_pkg::CH_CR:
            begin
                sel.red   = cr_gray;
                sel.green = cr_gray;
                sel.blue  = cr_gray;
            end
            default:
            begin
                // Pass-through, also taken by the unused selector code.
                sel.red   = pix.red;
                sel.green = pix.green;
                sel.blue  = pix.blue;
                sel.alpha = cfg.source_has_alpha ? pix.alpha : pcvl_pkg::COMP_MAX;
            end
        endcase
    end

    always_comb
    begin
        view = sel;
        if (cfg.lsb_view_enable)
        begin
            view.red   = {pcvl_pkg::COMP_W{sel.red[0]}};
            view.green = {pcvl_pkg::COMP_W{sel.green[0]}};
            view.blue  = {pcvl_pkg::COMP_W{sel.blue[0]}};
            view.alpha = cfg.source_has_alpha ? {pcvl_pkg::COMP_W{sel.alpha[0]}}
                                              : pcvl_pkg::COMP_MAX;
        end
    end

endmodule

FILE: design/pixel_channel_view_lsb_plane_unit.sv
// Top level of the pixel channel view block with optional least-significant-bit plane.
//
//   Channel       Signals                               Transaction
//   ------------  ------------------------------------  ------------------------------
//   Pixel in      start, busy, in_red..in_alpha         start high while busy low
//   View out      done, out_red..out_alpha              done high for one cycle
//   Config        psel, penable, pwrite, paddr, pwdata  APB write, pready always high
//
// One pixel is accepted in every cycle; busy is never raised.
// The view pixel appears with done after it passes the input register and then the weight
// multipliers and selection into the result register.
// Reset clears the valid flags and loads the register defaults (pass-through, LSB view off).
// The receiver cannot stall, so nothing is held back at the result side.
module pixel_channel_view_lsb_plane_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pcvl_pkg::ADDR_W-1:0]   paddr,
    input  logic [pcvl_pkg::DATA_W-1:0]   pwdata,
    output logic [pcvl_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          start,
    output logic                          busy,
    input  logic [pcvl_pkg::COMP_W-1:0]   in_red,
    input  logic [pcvl_pkg::COMP_W-1:0]   in_green,
    input  logic [pcvl_pkg::COMP_W-1:0]   in_blue,
    input  logic [pcvl_pkg::COMP_W-1:0]   in_alpha,
    output logic                          done,
    output logic [pcvl_pkg::COMP_W-1:0]   out_red,
    output logic [pcvl_pkg::COMP_W-1:0]   out_green,
    output logic [pcvl_pkg::COMP_W-1:0]   out_blue,
    output logic [pcvl_pkg::COMP_W-1:0]   out_alpha
);

    pcvl_pkg::cfg_t   cfg;
    pcvl_pkg::cfg_t   s1_cfg_reg;
    pcvl_pkg::pixel_t s1_pix_reg;
    pcvl_pkg::pixel_t res_pix_reg;
    pcvl_pkg::pixel_t view;
    logic             s1_valid_reg;
    logic             done_reg;
    logic             accept;

    pcvl_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            done_reg     <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg <= '{red: in_red, green: in_green, blue: in_blue, alpha: in_alpha};
            s1_cfg_reg <= cfg;
        end
        if (s1_valid_reg)
        begin
            res_pix_reg <= view;
        end
    end

    pcvl_view u_view (
        .cfg  (s1_cfg_reg),
        .pix  (s1_pix_reg),
        .view (view)
    );

    assign done      = done_reg;
    assign out_red   = res_pix_reg.red;
    assign out_green = res_pix_reg.green;
    assign out_blue  = res_pix_reg.blue;
    assign out_alpha = res_pix_reg.alpha;

`ifndef SYNTHESIS
    a_done_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 done)
        else $error("accepted pixel did not produce a result");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |=> done)
        else $error("input stage held a pixel but no result followed");

    a_done_needs_stage: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(s1_valid_reg))
        else $error("result strobe without a pixel in the input stage");

    a_alpha_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_cfg_reg.source_has_alpha |=> out_alpha == pcvl_pkg::COMP_MAX)
        else $error("alpha not opaque while the source has no alpha");

    a_lsb_plane: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_cfg_reg.lsb_view_enable
        |=> (out_red == '0 || out_red == pcvl_pkg::COMP_MAX)
            && (out_green == '0 || out_green == pcvl_pkg::COMP_MAX)
            && (out_blue == '0 || out_blue == pcvl_pkg::COMP_MAX))
        else $error("LSB view produced a component other than 0 or 255");
`endif

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the pixel channel view unit with its least-significant-bit plane.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CH_UNUSED = 3'd7;
    localparam int unsigned REG_UNMAPPED = 3;
    localparam int unsigned PHASES = 16;
    localparam int unsigned PIXELS_PER_PHASE = 122;

    localparam longint Q16_Y_R = 19595;
    localparam longint Q16_Y_G = 38470;
    localparam longint Q16_Y_B = 7471;
    localparam longint Q16_CB_R = 11058;
    localparam longint Q16_CB_G = 21710;
    localparam longint Q16_CB_B = 32768;
    localparam longint Q16_CR_R = 32768;
    localparam longint Q16_CR_G = 27439;
    localparam longint Q16_CR_B = 5329;
    localparam longint Q16_CHROMA_OFFSET = 128 * 65536;

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [pcvl_pkg::ADDR_W-1:0]   paddr;
    logic [pcvl_pkg::DATA_W-1:0]   pwdata;
    logic [pcvl_pkg::DATA_W-1:0]   prdata;
    logic                          pready;
    logic                          start;
    logic                          busy;
    logic [pcvl_pkg::COMP_W-1:0]   in_red;
    logic [pcvl_pkg::COMP_W-1:0]   in_green;
    logic [pcvl_pkg::COMP_W-1:0]   in_blue;
    logic [pcvl_pkg::COMP_W-1:0]   in_alpha;
    logic                          done;
    logic [pcvl_pkg::COMP_W-1:0]   out_red;
    logic [pcvl_pkg::COMP_W-1:0]   out_green;
    logic [pcvl_pkg::COMP_W-1:0]   out_blue;
    logic [pcvl_pkg::COMP_W-1:0]   out_alpha;

    pcvl_pkg::cfg_t   view_cfg;
    pcvl_pkg::pixel_t pending_views[$];
    int               mismatch_count;

    pixel_channel_view_lsb_plane_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .start     (start),
        .busy      (busy),
        .in_red    (in_red),
        .in_green  (in_green),
        .in_blue   (in_blue),
        .in_alpha  (in_alpha),
        .done      (done),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .out_alpha (out_alpha)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    initial
    begin
        #500000;
        $display("testbench: done, errors");
        $finish;
    end

    function automatic logic [pcvl_pkg::COMP_W-1:0] clamp_q16(input longint sum);
        if (sum < 0)
            return '0;
        if ((sum >>> 16) > 255)
            return pcvl_pkg::COMP_MAX;
        return sum[23:16];
    endfunction

    function automatic pcvl_pkg::pixel_t view_of(input pcvl_pkg::pixel_t src,
                                                 input pcvl_pkg::cfg_t c);
        longint r;
        longint g;
        longint b;
        logic [pcvl_pkg::COMP_W-1:0] gray;
        pcvl_pkg::pixel_t v;
        r = longint'(src.red);
        g = longint'(src.green);
        b = longint'(src.blue);
        v = '0;
        v.alpha = pcvl_pkg::COMP_MAX;
        case (c.channel_select) inside
            pcvl_pkg::CH_RED:   v.red = src.red;
            pcvl_pkg::CH_GREEN: v.green = src.green;
            pcvl_pkg::CH_BLUE:  v.blue = src.blue;
            pcvl_pkg::CH_LUMA, pcvl_pkg::CH_CB, pcvl_pkg::CH_CR:
            begin
                if (c.channel_select == pcvl_pkg::CH_LUMA)
                    gray = clamp_q16(Q16_Y_R * r + Q16_Y_G * g + Q16_Y_B * b);
                else if (c.channel_select == pcvl_pkg::CH_CB)
                    gray = clamp_q16(Q16_CHROMA_OFFSET - Q16_CB_R * r - Q16_CB_G * g
                                     + Q16_CB_B * b);
                else
                    gray = clamp_q16(Q16_CHROMA_OFFSET + Q16_CR_R * r - Q16_CR_G * g
                                     - Q16_CR_B * b);
                v.red = gray;
                v.green = gray;
                v.blue = gray;
            end
            default:
            begin
                v.red = src.red;
                v.green = src.green;
                v.blue = src.blue;
                v.alpha = c.source_has_alpha ? src.alpha : pcvl_pkg::COMP_MAX;
            end
        endcase
        if (c.lsb_view_enable)
        begin
            v.red = {pcvl_pkg::COMP_W{v.red[0]}};
            v.green = {pcvl_pkg::COMP_W{v.green[0]}};
            v.blue = {pcvl_pkg::COMP_W{v.blue[0]}};
            v.alpha = c.source_has_alpha ? {pcvl_pkg::COMP_W{v.alpha[0]}}
                                         : pcvl_pkg::COMP_MAX;
        end
        return v;
    endfunction

    function automatic logic [pcvl_pkg::COMP_W-1:0] random_comp();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return pcvl_pkg::COMP_MAX;
            2: return 8'd1;
            3: return 8'd254;
            default: return pcvl_pkg::COMP_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic pcvl_pkg::pixel_t random_pixel();
        pcvl_pkg::pixel_t p;
        p.red = random_comp();
        p.green = random_comp();
        p.blue = random_comp();
        p.alpha = random_comp();
        return p;
    endfunction

    task automatic compare_field(input string field,
                                 input logic [pcvl_pkg::COMP_W-1:0] expected,
                                 input logic [pcvl_pkg::COMP_W-1:0] actual);
        if (actual !== expected)
        begin
            mismatch_count++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, expected,
                     actual);
        end
    endtask

    always @(posedge clk)
    begin
        pcvl_pkg::pixel_t expected;
        if (rst_n && done)
        begin
            if (pending_views.size() == 0)
            begin
                mismatch_count++;
                $display("%0t ns: unexpected transaction, expected none, actual %h %h %h %h",
                         $time, out_red, out_green, out_blue, out_alpha);
            end
            else
            begin
                expected = pending_views.pop_front();
                compare_field("out_red", expected.red, out_red);
                compare_field("out_green", expected.green, out_green);
                compare_field("out_blue", expected.blue, out_blue);
                compare_field("out_alpha", expected.alpha, out_alpha);
            end
        end
    end

    task automatic send_pixel(input pcvl_pkg::pixel_t p);
        in_red <= p.red;
        in_green <= p.green;
        in_blue <= p.blue;
        in_alpha <= p.alpha;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_views.push_back(view_of(p, view_cfg));
        @(negedge clk);
    endtask

    task automatic pause_sender(input int unsigned cycles);
        start <= 1'b0;
        repeat (cycles)
            @(negedge clk);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (pending_views.size() != 0)
            @(negedge clk);
        repeat (4)
            @(negedge clk);
    endtask

    task automatic write_reg(input int unsigned index,
                             input logic [pcvl_pkg::DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= pcvl_pkg::ADDR_W'(index * 4);
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (index == pcvl_pkg::REG_CHANNEL_SELECT)
            view_cfg.channel_select = data[2:0];
        else if (index == pcvl_pkg::REG_LSB_VIEW_ENABLE)
            view_cfg.lsb_view_enable = data[0];
        else if (index == pcvl_pkg::REG_SOURCE_HAS_ALPHA)
            view_cfg.source_has_alpha = data[0];
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_pixel('{red: 8'd12, green: 8'd34, blue: 8'd56, alpha: 8'h80});
        send_pixel('{red: 8'hFF, green: 8'hFF, blue: 8'hFF, alpha: 8'h01});
        settle();
    endtask

    task automatic test_channel_views();
        pcvl_pkg::pixel_t corner[4];
        corner[0] = '{red: 8'hFF, green: 8'hFF, blue: 8'hFF, alpha: 8'hFF};
        corner[1] = '{red: 8'hFF, green: 8'h00, blue: 8'h00, alpha: 8'h01};
        corner[2] = '{red: 8'h00, green: 8'h00, blue: 8'hFF, alpha: 8'hFE};
        corner[3] = '{red: 8'h00, green: 8'hFF, blue: 8'hFF, alpha: 8'h00};
        for (int ch = pcvl_pkg::CH_RED; ch <= pcvl_pkg::CH_CR; ch++)
        begin
            write_reg(pcvl_pkg::REG_CHANNEL_SELECT, pcvl_pkg::DATA_W'(ch));
            send_pixel(corner[ch % 4]);
            send_pixel(corner[(ch + 1) % 4]);
            settle();
        end
    endtask

    task automatic test_pass_alpha();
        write_reg(pcvl_pkg::REG_CHANNEL_SELECT, pcvl_pkg::DATA_W'(pcvl_pkg::CH_PASS));
        write_reg(pcvl_pkg::REG_SOURCE_HAS_ALPHA, 32'd1);
        send_pixel('{red: 8'd1, green: 8'd2, blue: 8'd3, alpha: 8'hA5});
        send_pixel('{red: 8'h00, green: 8'h00, blue: 8'h00, alpha: 8'h00});
        settle();
    endtask

    task automatic test_lsb_plane();
        write_reg(pcvl_pkg::REG_LSB_VIEW_ENABLE, 32'd1);
        send_pixel('{red: 8'h55, green: 8'hAA, blue: 8'h01, alpha: 8'hFE});
        settle();
        write_reg(pcvl_pkg::REG_SOURCE_HAS_ALPHA, 32'd0);
        send_pixel('{red: 8'h55, green: 8'hAA, blue: 8'h01, alpha: 8'hFE});
        settle();
        write_reg(pcvl_pkg::REG_CHANNEL_SELECT, pcvl_pkg::DATA_W'(pcvl_pkg::CH_LUMA));
        send_pixel('{red: 8'hFF, green: 8'hFF, blue: 8'hFF, alpha: 8'h00});
        settle();
    endtask

    task automatic test_open_cases();
        // The unused selector code behaves as pass-through; upper data bits are dropped.
        write_reg(pcvl_pkg::REG_CHANNEL_SELECT, {29'h1ABCDEF0, CH_UNUSED});
        write_reg(pcvl_pkg::REG_LSB_VIEW_ENABLE, 32'hFFFF_FFFE);
        write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
        send_pixel('{red: 8'h81, green: 8'h7E, blue: 8'hC3, alpha: 8'h3C});
        settle();
    endtask

    task automatic test_random_stream();
        int unsigned burst_left;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase < 8)
                write_reg(pcvl_pkg::REG_CHANNEL_SELECT, {29'($urandom), 3'(phase)});
            else
                write_reg(pcvl_pkg::REG_CHANNEL_SELECT,
                          ($urandom_range(0, 1) ? $urandom : 32'd0) & ~32'd7
                          | pcvl_pkg::DATA_W'($urandom_range(0, 7)));
            write_reg(pcvl_pkg::REG_LSB_VIEW_ENABLE, $urandom);
            write_reg(pcvl_pkg::REG_SOURCE_HAS_ALPHA, $urandom);
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_UNMAPPED, $urandom);
            burst_left = $urandom_range(1, 30);
            for (int n = 0; n < PIXELS_PER_PHASE; n++)
            begin
                send_pixel(random_pixel());
                burst_left--;
                if (burst_left == 0)
                begin
                    pause_sender($urandom_range(1, 5));
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                             : $urandom_range(1, 30);
                end
            end
            settle();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        in_red = '0;
        in_green = '0;
        in_blue = '0;
        in_alpha = '0;
        mismatch_count = 0;
        view_cfg.channel_select = pcvl_pkg::CH_PASS;
        view_cfg.lsb_view_enable = 1'b0;
        view_cfg.source_has_alpha = 1'b0;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_channel_views();
        test_pass_alpha();
        test_lsb_plane();
        test_open_cases();
        test_random_stream();

        settle();
        repeat (8)
            @(negedge clk);
        if (mismatch_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
design/pcvl_pkg.sv
design/pcvl_regs.sv
design/pcvl_view.sv
design/pixel_channel_view_lsb_plane_unit.sv
verif/testbench.sv
